// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define CSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/csd_pkg.sv =====
`timescale 1ns / 1ps

package csd_pkg;

    localparam int BYTE_W      = 7;
    localparam int SVC_W       = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SERVICE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_REPEATS   = 1'd1;

    // First-byte classes (parity stripped)
    localparam logic [BYTE_W-1:0] XDS_FIRST_MIN  = 7'h01;
    localparam logic [BYTE_W-1:0] XDS_FIRST_MAX  = 7'h0F;
    localparam logic [BYTE_W-1:0] CTRL_FIRST_MIN = 7'h10;
    localparam logic [BYTE_W-1:0] CTRL_FIRST_MAX = 7'h1F;
    localparam int                CHANNEL_BIT    = 3;

    // Leading bytes of miscellaneous control codes
    localparam logic [BYTE_W-1:0] MISC_CH1_F1 = 7'h14;
    localparam logic [BYTE_W-1:0] MISC_CH1_F2 = 7'h15;
    localparam logic [BYTE_W-1:0] MISC_CH2_F1 = 7'h1C;
    localparam logic [BYTE_W-1:0] MISC_CH2_F2 = 7'h1D;

    // Miscellaneous second bytes
    localparam logic [BYTE_W-1:0] MISC_SECOND_MIN = 7'h20;
    localparam logic [BYTE_W-1:0] MISC_SECOND_MAX = 7'h2F;
    localparam logic [BYTE_W-1:0] MISC_RCL        = 7'h20;
    localparam logic [BYTE_W-1:0] MISC_RU2        = 7'h25;
    localparam logic [BYTE_W-1:0] MISC_RU3        = 7'h26;
    localparam logic [BYTE_W-1:0] MISC_RU4        = 7'h27;
    localparam logic [BYTE_W-1:0] MISC_RDC        = 7'h29;
    localparam logic [BYTE_W-1:0] MISC_TR         = 7'h2A;
    localparam logic [BYTE_W-1:0] MISC_RTD        = 7'h2B;

    typedef struct packed {
        logic              field_number;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
    } csd_pair_t;

    typedef struct packed {
        logic       [1:0]  field_channel;
        logic       [3:0]  chan_is_text;
        logic              repeat_pending;
        logic [BYTE_W-1:0] prior_first;
        logic [BYTE_W-1:0] prior_second;
    } csd_state_t;

    typedef struct packed {
        logic [SVC_W-1:0] target_service;
        logic             drop_repeated_controls;
    } csd_cfg_t;

    typedef struct packed {
        logic             accepted;
        logic             service_known;
        logic [SVC_W-1:0] pair_service;
    } csd_result_t;

endpackage

// ===== design/csd_stream_if.sv =====
`timescale 1ns / 1ps

interface csd_pair_if;
    logic       valid;
    logic       ready;
    logic       field_number;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, field_number, first_byte, second_byte, input ready);
    modport sink   (input valid, field_number, first_byte, second_byte, output ready);
    modport monitor (input valid, ready, field_number, first_byte, second_byte);
endinterface

interface csd_result_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       service_known;
    logic [2:0] pair_service;

    modport source (output valid, accepted, service_known, pair_service, input ready);
    modport sink   (input valid, accepted, service_known, pair_service, output ready);
    modport monitor (input valid, ready, accepted, service_known, pair_service);
endinterface

// ===== design/csd_decode.sv =====
`timescale 1ns / 1ps

module csd_decode import csd_pkg::*;
(
    input  csd_pair_t   pair,
    input  csd_state_t  state,
    input  csd_cfg_t    cfg,
    output csd_state_t  state_next,
    output csd_result_t result
);

    logic              no_service;
    logic              control;
    logic              misc;
    logic              ch;
    logic              txt;
    logic [SVC_W-1:0]  svc;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;

    assign b1 = pair.first_byte;
    assign b2 = pair.second_byte;

    assign no_service = (b1 == '0 && b2 == '0) || (b1 inside {[XDS_FIRST_MIN:XDS_FIRST_MAX]});
    assign control    = b1 inside {[CTRL_FIRST_MIN:CTRL_FIRST_MAX]};
    assign misc       = (b1 inside {MISC_CH1_F1, MISC_CH1_F2, MISC_CH2_F1, MISC_CH2_F2})
                        && (b2 inside {[MISC_SECOND_MIN:MISC_SECOND_MAX]});

    always_comb
    begin
        state_next = state;
        result     = '0;
        ch         = 1'b0;
        txt        = 1'b0;
        svc        = '0;
        if (!no_service)
        begin
            // a control pair picks the field's data channel, misc codes the mode
            if (control)
            begin
                state_next.field_channel[pair.field_number] = b1[CHANNEL_BIT];
                if (misc)
                begin
                    if (b2 inside {MISC_RCL, MISC_RU2, MISC_RU3, MISC_RU4, MISC_RDC})
                    begin
                        state_next.chan_is_text[{pair.field_number, b1[CHANNEL_BIT]}] = 1'b0;
                    end
                    else if (b2 inside {MISC_TR, MISC_RTD})
                    begin
                        state_next.chan_is_text[{pair.field_number, b1[CHANNEL_BIT]}] = 1'b1;
                    end
                end
            end

            ch  = state_next.field_channel[pair.field_number];
            txt = state_next.chan_is_text[{pair.field_number, ch}];
            svc = {pair.field_number, txt, ch};

            result.service_known = 1'b1;
            result.pair_service  = svc;

            if (svc == cfg.target_service)
            begin
                if (cfg.drop_repeated_controls && control)
                begin
                    if (state.repeat_pending && state.prior_first == b1
                        && state.prior_second == b2)
                    begin
                        // drop the repeat and disarm
                        state_next.repeat_pending = 1'b0;
                        result.accepted           = 1'b0;
                    end
                    else
                    begin
                        state_next.repeat_pending = 1'b1;
                        state_next.prior_first    = b1;
                        state_next.prior_second   = b2;
                        result.accepted           = 1'b1;
                    end
                end
                else
                begin
                    state_next.repeat_pending = 1'b0;
                    result.accepted           = 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/caption_service_demux.sv =====
`timescale 1ns / 1ps

// Channel        | Modport              | Payload
// ---------------+----------------------+---------------------------------------------
// caption_pair   | csd_pair_if.sink     | field_number, first_byte, second_byte
// service_result | csd_result_if.source | accepted, service_known, pair_service
// cfg_*          | plain write port     | cfg_we, cfg_index, cfg_data
//
// One pair per cycle unless stalled; results pass the pair then the result register.
// The rate is set by the single decode pass between the pair register and the result
// register, which also updates the channel, mode and repeat state.
// rst_n clears the valid flags, the decode state and both configuration registers.
// A stalled result holds in the result register while the pair register still takes one
// more transfer; caption_pair.ready drops only when both are full.

module caption_service_demux import csd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    csd_pair_if.sink               caption_pair,
    csd_result_if.source           service_result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Pair register stage
    logic        pair_valid_reg;
    logic        pair_valid_next;
    csd_pair_t   pair_reg;

    // Result register stage
    logic        res_valid_reg;
    logic        res_valid_next;
    csd_result_t res_reg;

    // Decode state and configuration
    csd_state_t  state_reg;
    csd_state_t  state_next;
    csd_cfg_t    cfg_reg;
    csd_result_t result;

    logic        in_transfer;
    logic        advance;

    // The result register frees up when empty or when its transfer happens this cycle
    assign advance            = !res_valid_reg || service_result.ready;
    assign caption_pair.ready = !pair_valid_reg || advance;
    assign in_transfer        = caption_pair.valid && caption_pair.ready;

    always_comb
    begin
        pair_valid_next = pair_valid_reg;
        if (in_transfer)
        begin
            pair_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pair_valid_next = 1'b0;
        end
    end

    assign res_valid_next = advance ? pair_valid_reg : res_valid_reg;

    csd_decode u_decode
    (
        .pair       (pair_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            pair_valid_reg <= pair_valid_next;
            res_valid_reg  <= res_valid_next;
            // commit the decode state only when the pair moves on to the result stage
            if (advance && pair_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_SERVICE: cfg_reg.target_service         <= cfg_data[SVC_W-1:0];
                REG_DROP_REPEATS:   cfg_reg.drop_repeated_controls <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Payload registers: strip parity on capture, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            pair_reg.field_number <= caption_pair.field_number;
            pair_reg.first_byte   <= caption_pair.first_byte[BYTE_W-1:0];
            pair_reg.second_byte  <= caption_pair.second_byte[BYTE_W-1:0];
        end
        if (advance && pair_valid_reg)
        begin
            res_reg <= result;
        end
    end

    assign service_result.valid         = res_valid_reg;
    assign service_result.accepted      = res_reg.accepted;
    assign service_result.service_known = res_reg.service_known;
    assign service_result.pair_service  = res_reg.pair_service;

endmodule

// ===== design/csd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic       acc,
    input logic       known,
    input logic [2:0] svc
);

    logic [4:0] payload;

    assign payload = {acc, known, svc};

    `CSD_ASSERT_IMPL(a_accept_known, clk, rst_n, valid && acc, known, "accept without service")
    `CSD_ASSERT_IMPL(a_unknown_zero, clk, rst_n, valid && !known, svc == 3'd0, "stray service code")
    `CSD_ASSERT_NEXT(a_valid_holds, clk, rst_n, valid && !ready, valid, "result withdrawn")
    `CSD_ASSERT_NEXT(a_payload_holds, clk, rst_n, valid && !ready, $stable(payload), "result moved")

endmodule

bind caption_service_demux csd_checker u_csd_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .valid (service_result.valid),
    .ready (service_result.ready),
    .acc   (service_result.accepted),
    .known (service_result.service_known),
    .svc   (service_result.pair_service)
);
